### rtl/core/sync_length_image_deframer_top_macros.svh
// assertion helpers for the deframer
`ifndef SYNC_LENGTH_IMAGE_DEFRAMER_TOP_MACROS_SVH
`define SYNC_LENGTH_IMAGE_DEFRAMER_TOP_MACROS_SVH

// implication checked at every clock edge outside reset
`define SLD_ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// implication checked in the cycle after the condition
`define SLD_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### rtl/core/sld_pkg.sv
package sld_pkg;

    typedef enum logic [1:0] {
        EV_DATA   = 2'd0,
        EV_DONE   = 2'd1,
        EV_REJECT = 2'd2
    } event_t;

    typedef enum logic [1:0] {
        CFG_SYNC_VALUE = 2'd0,
        CFG_MAX_LENGTH = 2'd1
    } cfg_index_t;

    localparam logic [7:0]  SYNC_VALUE_RESET = 8'h69;
    localparam logic [23:0] MAX_LENGTH_RESET = 24'd98304;

endpackage

### rtl/core/sync_length_image_deframer_top.sv
// Sync-byte, length-prefixed frame receiver. Bytes arrive on rx_byte; while hunting every byte
// is dropped until one equals the sync_value register. The next four bytes form a little-endian
// length. A length above max_length (or above what the COUNT_BITS payload counter can index)
// gives one rejection result and the block hunts again. Otherwise each payload byte comes out
// with its index, then four little-endian trailer bytes are gathered (CRC, not checked) and one
// frame-complete result carries the length and trailer. One byte is taken per clock cycle: the
// state update and the result are a single registered step, and a two-entry output stage
// (result register plus skid register) lets input keep flowing while a result waits. Input
// stalls only when both output entries are full. Configuration writes are always taken.
module sync_length_image_deframer_top #(
    parameter int COUNT_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input byte channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            rx_byte,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            event_res,
    output logic [7:0]            data_byte,
    output logic [23:0]           byte_index,
    output logic [31:0]           frame_length,
    output logic [31:0]           trailer_word,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [23:0]           cfg_data
);

    `include "sync_length_image_deframer_top_macros.svh"

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_LEN   = 2'd1,
        PH_DATA  = 2'd2,
        PH_TRAIL = 2'd3
    } phase_t;

    typedef struct packed {
        sld_pkg::event_t       ev;
        logic [7:0]            data;
        logic [COUNT_BITS-1:0] index;
        logic [31:0]           length;
        logic [31:0]           trailer;
    } result_t;

    phase_t                phase_reg, phase_next;
    logic [1:0]            hdr_count_reg, hdr_count_next;
    logic [31:0]           length_reg, length_next;
    logic [COUNT_BITS-1:0] payload_count_reg, payload_count_next;
    logic [31:0]           trailer_reg, trailer_next;
    logic [7:0]            sync_value_reg;
    logic [23:0]           max_length_reg;

    result_t               out_reg, skid_reg, res;
    logic                  out_valid_reg, skid_valid_reg;
    logic                  res_valid;

    logic                  in_fire, out_fire;
    logic [31:0]           len_full, trl_full;
    logic [COUNT_BITS-1:0] count_inc;
    logic                  len_too_big;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        len_full = length_reg;
        len_full[hdr_count_reg*8 +: 8] = rx_byte;
        trl_full = trailer_reg;
        trl_full[hdr_count_reg*8 +: 8] = rx_byte;
        count_inc = payload_count_reg + COUNT_BITS'(1);
        len_too_big = (len_full > {8'd0, max_length_reg}) || ((len_full >> COUNT_BITS) != 32'd0);
    end

    always_comb
    begin
        phase_next         = phase_reg;
        hdr_count_next     = hdr_count_reg;
        length_next        = length_reg;
        payload_count_next = payload_count_reg;
        trailer_next       = trailer_reg;
        res_valid          = 1'b0;
        res                = '0;
        res.ev             = sld_pkg::EV_DATA;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == sync_value_reg)
                begin
                    phase_next     = PH_LEN;
                    hdr_count_next = 2'd0;
                    length_next    = 32'd0;
                end
            end
            PH_LEN:
            begin
                length_next    = len_full;
                hdr_count_next = hdr_count_reg + 2'd1;
                if (hdr_count_reg == 2'd3)
                begin
                    if (len_too_big)
                    begin
                        phase_next = PH_HUNT;
                        res_valid  = 1'b1;
                        res.ev     = sld_pkg::EV_REJECT;
                        res.length = len_full;
                    end
                    else
                    begin
                        payload_count_next = '0;
                        trailer_next       = 32'd0;
                        phase_next         = (len_full == 32'd0) ? PH_TRAIL : PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                res_valid          = 1'b1;
                res.ev             = sld_pkg::EV_DATA;
                res.data           = rx_byte;
                res.index          = payload_count_reg;
                payload_count_next = count_inc;
                if (32'(count_inc) == length_reg)
                begin
                    phase_next     = PH_TRAIL;
                    hdr_count_next = 2'd0;
                    trailer_next   = 32'd0;
                end
            end
            PH_TRAIL:
            begin
                trailer_next   = trl_full;
                hdr_count_next = hdr_count_reg + 2'd1;
                if (hdr_count_reg == 2'd3)
                begin
                    phase_next  = PH_HUNT;
                    res_valid   = 1'b1;
                    res.ev      = sld_pkg::EV_DONE;
                    res.length  = length_reg;
                    res.trailer = trl_full;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HUNT;
            hdr_count_reg     <= 2'd0;
            length_reg        <= 32'd0;
            payload_count_reg <= '0;
            trailer_reg       <= 32'd0;
            sync_value_reg    <= sld_pkg::SYNC_VALUE_RESET;
            max_length_reg    <= sld_pkg::MAX_LENGTH_RESET;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    sld_pkg::CFG_SYNC_VALUE: sync_value_reg <= cfg_data[7:0];
                    sld_pkg::CFG_MAX_LENGTH: max_length_reg <= cfg_data;
                    default:                 ;
                endcase
            end
            if (in_fire)
            begin
                phase_reg         <= phase_next;
                hdr_count_reg     <= hdr_count_next;
                length_reg        <= length_next;
                payload_count_reg <= payload_count_next;
                trailer_reg       <= trailer_next;
            end
            // two-entry output: skid drains first, input is held off while it is full
            if (skid_valid_reg)
            begin
                if (out_fire)
                begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (in_fire && res_valid)
            begin
                if (!out_valid_reg || out_fire)
                begin
                    out_reg       <= res;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_reg       <= res;
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = out_reg.ev;
    assign data_byte    = out_reg.data;
    assign byte_index   = 24'(out_reg.index);
    assign frame_length = out_reg.length;
    assign trailer_word = out_reg.trailer;

    `SLD_ASSERT_IMPLY(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full with empty output")
    `SLD_ASSERT_IMPLY(a_data_inside_frame, phase_reg == PH_DATA,
        (length_reg != 32'd0) && (32'(payload_count_reg) < length_reg),
        "payload count outside frame length")
    `SLD_ASSERT_NEXT(a_data_gives_result, in_fire && phase_reg == PH_DATA, out_valid_reg,
        "payload byte left no result")
    `SLD_ASSERT_IMPLY(a_data_fields_clear, out_valid_reg && out_reg.ev == sld_pkg::EV_DATA,
        (out_reg.length == 32'd0) && (out_reg.trailer == 32'd0),
        "payload result carries frame fields")
    `SLD_ASSERT_IMPLY(a_reject_fields, out_valid_reg && out_reg.ev == sld_pkg::EV_REJECT,
        (out_reg.data == 8'd0) && (out_reg.trailer == 32'd0),
        "rejection result carries payload fields")

endmodule
